[src/crfb_pkg.sv]
// Shared types and constants for the control register file with banked stack pointer.
package crfb_pkg;

	localparam int DATA_W  = 32;
	localparam int MODE_W  = 2;
	localparam int INDEX_W = 4;
	localparam int SPARE_N = 3;

	localparam logic [MODE_W-1:0] MODE_RD_CTRL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WR_CTRL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RD_SP   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_WR_SP   = 2'd3;

	localparam logic [INDEX_W-1:0] CR_STATUS  = 4'd0;
	localparam logic [INDEX_W-1:0] CR_COND    = 4'd1;
	localparam logic [INDEX_W-1:0] CR_INT_SP  = 4'd2;
	localparam logic [INDEX_W-1:0] CR_USER_SP = 4'd3;
	localparam logic [INDEX_W-1:0] CR_SPARE0  = 4'd4;
	localparam logic [INDEX_W-1:0] CR_SPARE1  = 4'd5;
	localparam logic [INDEX_W-1:0] CR_SPARE2  = 4'd6;

	localparam int BIT_BSM = 15;
	localparam int BIT_BIE = 14;
	localparam int BIT_BC  = 8;
	localparam int BIT_SM  = 7;
	localparam int BIT_IE  = 6;
	localparam int BIT_C   = 0;

	typedef logic [MODE_W-1:0] mode_t;

	typedef struct packed {
		logic                fire;
		mode_t               mode;
		logic [INDEX_W-1:0]  idx;
		logic [DATA_W-1:0]   wdata;
	} req_t;

endpackage

[src/control_register_file_banked_sp_unit.sv]
// Top level of the control register file with banked stack pointer.
// Each word is one access: a read or write of a control register, or of the
// live stack pointer. The unit takes one word per cycle while the input is not
// stalled and returns one result word per access: the access is captured in an
// input register, resolved against the register state by combinational
// muxing and status bit packing, and captured in the result register. Writes
// return zero. A stall on the result side holds the input register, which
// then stalls the input side. Reset clears the valid flags and the register state, not the data registers.
module control_register_file_banked_sp_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [crfb_pkg::MODE_W-1:0]    mode,
	input  logic [crfb_pkg::INDEX_W-1:0]   reg_index,
	input  logic [crfb_pkg::DATA_W-1:0]    write_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [crfb_pkg::DATA_W-1:0]    read_data
);
	import crfb_pkg::*;

	logic               valid_s1;
	mode_t              mode_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic [DATA_W-1:0]  wdata_s1;
	logic               out_valid_q;
	logic [DATA_W-1:0]  read_data_q;
	logic               advance;
	logic               load_s1;
	req_t               req;
	logic [DATA_W-1:0]  rdata;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	assign req.fire  = advance;
	assign req.mode  = mode_s1;
	assign req.idx   = idx_s1;
	assign req.wdata = wdata_s1;

	crfb_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1  <= mode;
			idx_s1   <= reg_index;
			wdata_s1 <= write_value;
		end
		if (advance) read_data_q <= rdata;
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while the result path was free");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (mode_s1 == MODE_WR_CTRL || mode_s1 == MODE_WR_SP))
		|=> (out_valid && read_data == '0))
		else $error("write access returned a nonzero result");

	a_result_follows_access: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("resolved access produced no result word");
`endif

endmodule

[src/crfb_regs.sv]
// Register storage, status packing and stack pointer banking.
module crfb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  crfb_pkg::req_t               req,
	output logic [crfb_pkg::DATA_W-1:0]  rdata
);
	import crfb_pkg::*;

	logic              cond_q;
	logic              ie_q;
	logic              sm_q;
	logic              bcond_q;
	logic              bie_q;
	logic              bsm_q;
	logic [DATA_W-1:0] live_sp_q;
	logic [DATA_W-1:0] int_sp_q;
	logic [DATA_W-1:0] user_sp_q;
	logic [DATA_W-1:0] spare_q [SPARE_N];
	logic [DATA_W-1:0] ctrl_rd;
	logic              new_sm;

	assign new_sm = req.wdata[BIT_SM];

	always_comb begin
		ctrl_rd = '0;
		unique case (req.idx)
			CR_STATUS: begin
				ctrl_rd[BIT_BSM] = bsm_q;
				ctrl_rd[BIT_BIE] = bie_q;
				ctrl_rd[BIT_BC]  = bcond_q;
				ctrl_rd[BIT_SM]  = sm_q;
				ctrl_rd[BIT_IE]  = ie_q;
				ctrl_rd[BIT_C]   = cond_q;
			end
			CR_COND:    ctrl_rd[BIT_C] = cond_q;
			CR_INT_SP:  ctrl_rd = sm_q ? int_sp_q : live_sp_q;
			CR_USER_SP: ctrl_rd = sm_q ? live_sp_q : user_sp_q;
			CR_SPARE0:  ctrl_rd = spare_q[0];
			CR_SPARE1:  ctrl_rd = spare_q[1];
			CR_SPARE2:  ctrl_rd = spare_q[2];
			default:    ctrl_rd = '0;
		endcase
	end

	always_comb begin
		unique case (req.mode)
			MODE_RD_CTRL: rdata = ctrl_rd;
			MODE_RD_SP:   rdata = live_sp_q;
			default:      rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_q     <= 1'b0;
			ie_q       <= 1'b0;
			sm_q       <= 1'b0;
			bcond_q    <= 1'b0;
			bie_q      <= 1'b0;
			bsm_q      <= 1'b0;
			live_sp_q  <= '0;
			int_sp_q   <= '0;
			user_sp_q  <= '0;
			spare_q[0] <= '0;
			spare_q[1] <= '0;
			spare_q[2] <= '0;
		end else if (req.fire) begin
			unique case (req.mode)
				MODE_WR_CTRL: begin
					unique case (req.idx)
						CR_STATUS: begin
							bsm_q   <= req.wdata[BIT_BSM];
							bie_q   <= req.wdata[BIT_BIE];
							bcond_q <= req.wdata[BIT_BC];
							sm_q    <= new_sm;
							ie_q    <= req.wdata[BIT_IE];
							cond_q  <= req.wdata[BIT_C];
							// A change of stack mode parks the live pointer in its own bank.
							if (new_sm != sm_q) begin
								if (sm_q) begin
									user_sp_q <= live_sp_q;
									live_sp_q <= int_sp_q;
								end else begin
									int_sp_q  <= live_sp_q;
									live_sp_q <= user_sp_q;
								end
							end
						end
						CR_COND: cond_q <= req.wdata[BIT_C];
						CR_INT_SP: begin
							if (sm_q) int_sp_q <= req.wdata;
							else live_sp_q <= req.wdata;
						end
						CR_USER_SP: begin
							if (sm_q) live_sp_q <= req.wdata;
							else user_sp_q <= req.wdata;
						end
						CR_SPARE0: spare_q[0] <= req.wdata;
						CR_SPARE1: spare_q[1] <= req.wdata;
						CR_SPARE2: spare_q[2] <= req.wdata;
						default: begin
						end
					endcase
				end
				MODE_WR_SP: live_sp_q <= req.wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

[sim/control_register_file_banked_sp_unit_tb.sv]
// Self-checking testbench for the control register file with banked stack pointer.
`timescale 1ns / 1ps

module control_register_file_banked_sp_unit_tb;
	import crfb_pkg::*;

	typedef enum int {PH_DIRECTED, PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE,
		PH_DRAIN} phase_t;

	typedef struct packed {
		mode_t               m;
		logic [INDEX_W-1:0]  idx;
		logic [DATA_W-1:0]   val;
		logic                typed;
		logic [DATA_W-1:0]   rd;
	} dir_row_t;

	localparam int DIR_N = 26;
	localparam int RAND_PER_PHASE = 120;
	localparam int HOLD_OFF_CYCLES = 100;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	mode_t               mode;
	logic [INDEX_W-1:0]  reg_index;
	logic [DATA_W-1:0]   write_value;
	logic                out_valid;
	logic                out_stall;
	logic [DATA_W-1:0]   read_data;

	phase_t phase = PH_DIRECTED;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_cnt = 0;
	int result_cnt = 0;
	int bank_switch_cnt = 0;
	int mode_cnt [4] = '{0, 0, 0, 0};
	bit held_off = 1'b0;

	logic                st_cond, st_ie, st_sm, st_bcond, st_bie, st_bsm;
	logic [DATA_W-1:0]   sp_live, sp_int_bank, sp_user_bank;
	logic [DATA_W-1:0]   spare_regs [SPARE_N];
	logic [DATA_W-1:0]   pending_read_data [$];

	dir_row_t directed_rows [DIR_N] = '{
		'{MODE_RD_CTRL, CR_STATUS,  32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_COND,    32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_INT_SP,  32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_USER_SP, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_RD_SP,   4'hF,       32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{MODE_WR_CTRL, 4'hF,       32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{MODE_RD_CTRL, 4'hF,       32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_RD_CTRL, 4'h7,       32'h0000_0000, 1'b1, 32'h0000_0000},
		'{MODE_WR_SP,   CR_STATUS,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{MODE_RD_SP,   CR_COND,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
		'{MODE_RD_CTRL, CR_INT_SP,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
		'{MODE_WR_CTRL, CR_USER_SP, 32'h1234_5678, 1'b1, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_STATUS,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_STATUS,  32'h0000_0000, 1'b1, 32'h0000_C1C1},
		'{MODE_RD_SP,   CR_SPARE0,  32'h0000_0000, 1'b0, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_INT_SP,  32'h0000_0000, 1'b0, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_STATUS,  32'h0000_0080, 1'b0, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_STATUS,  32'h0000_0000, 1'b0, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_COND,    32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_COND,    32'h0000_0000, 1'b0, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_COND,    32'h0000_0001, 1'b0, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_STATUS,  32'h0000_0000, 1'b0, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_USER_SP, 32'h0000_0000, 1'b0, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_SPARE0,  32'hA5A5_A5A5, 1'b0, 32'h0000_0000},
		'{MODE_WR_CTRL, CR_SPARE2,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
		'{MODE_RD_CTRL, CR_SPARE0,  32'h0000_0000, 1'b0, 32'h0000_0000}
	};

	control_register_file_banked_sp_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.reg_index  (reg_index),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [DATA_W-1:0] status_word();
		logic [DATA_W-1:0] w;
		w = '0;
		w[BIT_BSM] = st_bsm;
		w[BIT_BIE] = st_bie;
		w[BIT_BC]  = st_bcond;
		w[BIT_SM]  = st_sm;
		w[BIT_IE]  = st_ie;
		w[BIT_C]   = st_cond;
		return w;
	endfunction

	// Applies one access to the shadow state and returns the word the unit must return.
	function automatic logic [DATA_W-1:0] resolve_access(mode_t m, logic [INDEX_W-1:0] i,
			logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] rd;
		logic prev_sm;
		rd = '0;
		case (m)
			MODE_RD_CTRL: begin
				case (i)
					CR_STATUS: rd = status_word();
					CR_COND: rd = {{(DATA_W-1){1'b0}}, st_cond};
					CR_INT_SP: rd = st_sm ? sp_int_bank : sp_live;
					CR_USER_SP: rd = st_sm ? sp_live : sp_user_bank;
					CR_SPARE0, CR_SPARE1, CR_SPARE2: rd = spare_regs[i - CR_SPARE0];
					default: rd = '0;
				endcase
			end
			MODE_WR_CTRL: begin
				case (i)
					CR_STATUS: begin
						prev_sm = st_sm;
						st_bsm = v[BIT_BSM];
						st_bie = v[BIT_BIE];
						st_bcond = v[BIT_BC];
						st_sm = v[BIT_SM];
						st_ie = v[BIT_IE];
						st_cond = v[BIT_C];
						if (prev_sm != st_sm) begin
							bank_switch_cnt++;
							if (prev_sm) begin
								sp_user_bank = sp_live;
								sp_live = sp_int_bank;
							end else begin
								sp_int_bank = sp_live;
								sp_live = sp_user_bank;
							end
						end
					end
					CR_COND: st_cond = v[0];
					CR_INT_SP: begin
						if (st_sm) sp_int_bank = v;
						else sp_live = v;
					end
					CR_USER_SP: begin
						if (st_sm) sp_live = v;
						else sp_user_bank = v;
					end
					CR_SPARE0, CR_SPARE1, CR_SPARE2: spare_regs[i - CR_SPARE0] = v;
					default: ;
				endcase
			end
			MODE_RD_SP: rd = sp_live;
			default: sp_live = v;
		endcase
		return rd;
	endfunction

	task automatic send_word(mode_t m, logic [INDEX_W-1:0] i, logic [DATA_W-1:0] v,
			logic typed, logic [DATA_W-1:0] typed_rd);
		logic [DATA_W-1:0] predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		reg_index <= i;
		write_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = resolve_access(m, i, v);
		pending_read_data.push_back(typed ? typed_rd : predicted);
		mode_cnt[m]++;
	endtask

	task automatic send_random_words(int n);
		mode_t m;
		logic [INDEX_W-1:0] i;
		logic [DATA_W-1:0] v;
		int r;
		int k;
		for (int n_sent = 0; n_sent < n; n_sent++) begin
			m = mode_t'($urandom_range(3));
			r = $urandom_range(99);
			if (r < 6) i = INDEX_W'($urandom_range(15, 7));
			else if (r < 26) i = CR_STATUS;
			else i = INDEX_W'($urandom_range(6));
			k = $urandom_range(9);
			if (k == 0) v = '0;
			else if (k == 1) v = '1;
			else v = $urandom();
			send_word(m, i, v, 1'b0, '0);
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (phase == PH_PRESSURE && !held_off) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_cnt++;
			if (pending_read_data.size() == 0) begin
				$error("read_data: expected none, actual %h", read_data);
				fail_cnt++;
			end else begin
				if (read_data !== pending_read_data[0]) begin
					$error("read_data: expected %h, actual %h", pending_read_data[0], read_data);
					fail_cnt++;
				end
				void'(pending_read_data.pop_front());
			end
		end
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		st_cond = 1'b0;
		st_ie = 1'b0;
		st_sm = 1'b0;
		st_bcond = 1'b0;
		st_bie = 1'b0;
		st_bsm = 1'b0;
		sp_live = '0;
		sp_int_bank = '0;
		sp_user_bank = '0;
		for (int s = 0; s < SPARE_N; s++) spare_regs[s] = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_RD_CTRL;
		reg_index = CR_STATUS;
		write_value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++)
			send_word(directed_rows[r].m, directed_rows[r].idx, directed_rows[r].val,
				directed_rows[r].typed, directed_rows[r].rd);

		phase = PH_FREE;
		send_idle_pct = 0;
		stall_pct = 0;
		send_random_words(RAND_PER_PHASE);

		phase = PH_SEND_IDLE;
		send_idle_pct = 87;
		stall_pct = 0;
		send_random_words(RAND_PER_PHASE);

		phase = PH_RECV_STALL;
		send_idle_pct = 0;
		stall_pct = 87;
		send_random_words(RAND_PER_PHASE);

		phase = PH_BOTH;
		send_idle_pct = 18;
		stall_pct = 18;
		send_random_words(RAND_PER_PHASE);

		phase = PH_PRESSURE;
		send_idle_pct = 0;
		stall_pct = 0;
		send_random_words(RAND_PER_PHASE);

		phase = PH_DRAIN;
		in_valid <= 1'b0;
		while (pending_read_data.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Accesses: %0d control reads, %0d control writes, %0d sp reads, %0d sp writes.",
			mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
		$display("Results checked: %0d, stack bank switches: %0d, under idle, stall and backpressure.",
			result_cnt, bank_switch_cnt);
		if (fail_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
src/crfb_pkg.sv
src/crfb_regs.sv
src/control_register_file_banked_sp_unit.sv
sim/control_register_file_banked_sp_unit_tb.sv
